// ===== design/sonar_threshold_bottom_detect_core_macros.svh =====
// Assertion macros for the bottom detector checker.
// Standalone header; no dependencies.
`ifndef SONAR_THRESHOLD_BOTTOM_DETECT_CORE_MACROS_SVH
`define SONAR_THRESHOLD_BOTTOM_DETECT_CORE_MACROS_SVH

`define STBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbd: implication check failed");

`define STBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbd: next-cycle check failed");

`endif

// ===== design/stbd_pkg.sv =====
// Shared constants and types of the sonar bottom detector.
// No dependencies.
package stbd_pkg;

  localparam int unsigned AMP_BITS        = 16;
  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned PCT_W           = 7;
  localparam int unsigned BLANK_W         = 13;
  localparam int unsigned IDX_OUT_W       = 12;
  localparam int unsigned CONF_W          = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 13;
  localparam int unsigned DVD_W           = 2 * AMP_BITS;
  localparam int unsigned THR_W           = AMP_BITS + 1;
  localparam int unsigned RECIP_W         = 24;
  localparam int unsigned RECIP_SHIFT     = 30;

  localparam logic [PCT_W-1:0]     PCT_RESET = PCT_W'(50);
  // ceil(2^30 / 100): exact floor division by 100 for products below 2^23
  localparam logic [RECIP_W-1:0]   PCT_RECIP = RECIP_W'(10737419);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_PERCENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLANKING_COUNT    = CFG_IDX_W'(1);

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dividend;
    logic [AMP_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] hit_index;
    logic [AMP_BITS-1:0]  peak;
    logic [CONF_W-1:0]    conf;
  } result_t;

endpackage

// ===== design/stbd_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on stbd_pkg.
module stbd_div import stbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic                busy_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [AMP_BITS-1:0] rem_q, dvs_q;
  logic [AMP_BITS:0]   rem_sh, diff;
  logic                ge;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[AMP_BITS-1:0] : rem_sh[AMP_BITS-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

// ===== design/stbd_queue.sv =====
// Two-entry job queue between the sample loader and the scan engine.
// Depends on stbd_pkg.
module stbd_queue import stbd_pkg::*; #(
  parameter int unsigned W = AMP_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic         empty_o
);

  logic [W-1:0] slot_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_data_i;
  end

  assign pop_data_o = slot_q[rptr_q];
  assign empty_o    = cnt_q == 2'd0;

endmodule

// ===== design/stbd_front.sv =====
// Sample loader: counts samples, writes the store, tracks the ping peak.
// Depends on stbd_pkg.
module stbd_front import stbd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned IW = $clog2(MAX_SAMPLES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [AMP_BITS-1:0] amp_i,
  input  logic                last_i,
  input  logic [BLANK_W-1:0]  blank_i,
  output logic                wr_en_o,
  output logic [IW-1:0]       wr_addr_o,
  output logic [AMP_BITS-1:0] wr_data_o,
  output logic                push_o,
  output logic [CW-1:0]       push_n_o,
  output logic [AMP_BITS-1:0] push_peak_o
);

  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AMP_BITS-1:0] peak_q, peak_d;
  logic                room, counted;

  always_comb begin
    room    = 32'(cnt_q) < MAX_SAMPLES;
    counted = room && (32'(cnt_q) >= 32'(blank_i));
    cnt_d   = room ? cnt_q + CW'(1) : cnt_q;
    peak_d  = (counted && amp_i > peak_q) ? amp_i : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      peak_q <= '0;
    end else if (acc_i) begin
      cnt_q  <= last_i ? '0 : cnt_d;
      peak_q <= last_i ? '0 : peak_d;
    end
  end

  assign wr_en_o     = acc_i && room;
  assign wr_addr_o   = cnt_q[IW-1:0];
  assign wr_data_o   = amp_i;
  assign push_o      = acc_i && last_i;
  assign push_n_o    = cnt_d;
  assign push_peak_o = peak_d;

endmodule

// ===== design/stbd_back.sv =====
// Scan engine: sample store, threshold, first sustained crossing, confidence.
// Depends on stbd_pkg; drives the stbd_div through request structs.
module stbd_back import stbd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned IW = $clog2(MAX_SAMPLES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [IW-1:0]       wr_addr_i,
  input  logic [AMP_BITS-1:0] wr_data_i,
  input  logic                job_valid_i,
  input  logic [CW-1:0]       job_n_i,
  input  logic [AMP_BITS-1:0] job_peak_i,
  output logic                job_pop_o,
  input  logic [PCT_W-1:0]    pct_i,
  input  logic [BLANK_W-1:0]  blank_i,
  output div_req_t            div_req_o,
  input  div_rsp_t            div_rsp_i,
  output logic                active_o,
  output logic                res_valid_o,
  output result_t             res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_THR,
    ST_SCAN,
    ST_CONF_WAIT
  } state_e;

  state_e              state_q;
  logic [AMP_BITS-1:0] mem [MAX_SAMPLES];
  logic [AMP_BITS-1:0] rdata_q;

  logic [CW-1:0]             n_q, rd_addr_q, data_idx_q, prev_idx_q, hit_idx_q;
  logic [AMP_BITS-1:0]       peak_q, prev_amp_q;
  logic [THR_W-1:0]          thr_q, thr_d;
  logic [AMP_BITS+PCT_W-1:0] prod_q;
  logic                      rd_vld_q, have_prev_q;
  div_req_t                  div_req_q;
  logic                      res_valid_q;
  result_t                   res_q;

  logic                              issue, rd_en, last_data, pair_hit, last_hit;
  logic [AMP_BITS+PCT_W-1:0]         prod;
  logic [AMP_BITS+PCT_W+RECIP_W-1:0] thr_prod;
  logic [THR_W-1:0]                  thr_quot;
  logic [DVD_W-1:0]                  conf_prev, conf_cur;

  function automatic logic [DVD_W-1:0] conf_dividend(input logic [AMP_BITS-1:0] a);
    conf_dividend = {a, AMP_BITS'(0)} - DVD_W'(a);
  endfunction

  always_comb begin
    issue     = 32'(rd_addr_q) < 32'(n_q);
    rd_en     = (state_q == ST_SCAN) && issue;
    last_data = data_idx_q == (n_q - CW'(1));
    pair_hit  = have_prev_q && (THR_W'(prev_amp_q) >= thr_q)
                && (THR_W'(rdata_q) >= (thr_q >> 1));
    last_hit  = THR_W'(rdata_q) >= thr_q;
    prod      = (AMP_BITS + PCT_W)'(peak_q) * (AMP_BITS + PCT_W)'(pct_i);
    thr_prod  = (AMP_BITS + PCT_W + RECIP_W)'(prod_q)
                * (AMP_BITS + PCT_W + RECIP_W)'(PCT_RECIP);
    thr_quot  = thr_prod[RECIP_SHIFT +: THR_W];
    conf_prev = conf_dividend(prev_amp_q);
    conf_cur  = conf_dividend(rdata_q);
    thr_d     = (thr_quot == '0) ? THR_W'(1) : thr_quot;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      peak_q      <= '0;
      thr_q       <= '0;
      prod_q      <= '0;
      rd_addr_q   <= '0;
      data_idx_q  <= '0;
      prev_idx_q  <= '0;
      prev_amp_q  <= '0;
      hit_idx_q   <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      div_req_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q     <= 1'b0;
      div_req_q.start <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            n_q    <= job_n_i;
            peak_q <= job_peak_i;
            if (job_peak_i == '0) begin
              res_q       <= '0;
              res_valid_q <= 1'b1;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= prod;
          state_q <= ST_THR;
        end
        ST_THR: begin
          thr_q       <= thr_d;
          rd_addr_q   <= CW'(blank_i);
          rd_vld_q    <= 1'b0;
          have_prev_q <= 1'b0;
          state_q     <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_vld_q   <= issue;
          data_idx_q <= rd_addr_q;
          if (issue) rd_addr_q <= rd_addr_q + CW'(1);
          if (rd_vld_q) begin
            if (pair_hit) begin
              hit_idx_q <= prev_idx_q;
              div_req_q <= '{start: 1'b1, dividend: conf_prev, divisor: peak_q};
              state_q   <= ST_CONF_WAIT;
            end else if (last_data) begin
              if (last_hit) begin
                hit_idx_q <= data_idx_q;
                div_req_q <= '{start: 1'b1, dividend: conf_cur, divisor: peak_q};
                state_q   <= ST_CONF_WAIT;
              end else begin
                res_q       <= '{found: 1'b0, hit_index: '0, peak: peak_q, conf: '0};
                res_valid_q <= 1'b1;
                state_q     <= ST_IDLE;
              end
            end else begin
              prev_amp_q  <= rdata_q;
              prev_idx_q  <= data_idx_q;
              have_prev_q <= 1'b1;
            end
          end else if (!issue) begin
            res_q       <= '{found: 1'b0, hit_index: '0, peak: peak_q, conf: '0};
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_CONF_WAIT: begin
          if (div_rsp_i.done) begin
            res_q <= '{found: 1'b1, hit_index: IDX_OUT_W'(hit_idx_q), peak: peak_q,
                       conf: div_rsp_i.quot[CONF_W-1:0]};
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign job_pop_o   = (state_q == ST_IDLE) && job_valid_i;
  assign active_o    = state_q != ST_IDLE;
  assign div_req_o   = div_req_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/sonar_threshold_bottom_detect_core.sv =====
// Sonar bottom detector. Takes one sample per cycle while busy is low. For a ping
// with a zero peak, done_o rises straight from idle without a scan; otherwise the
// threshold is formed, the scan runs from blanking b to the last of the n samples, and
// on a hit the 32-step confidence division runs before done_o rises; the scan
// reads one stored sample per cycle. busy stays high from the last sample to the result.
// Reset clears counters and peak, sets percent 50 and blanking 0; store contents are undefined.
module sonar_threshold_bottom_detect_core import stbd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [AMP_BITS-1:0]   sample_amplitude_i,
  input  logic                  ping_end_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [IDX_OUT_W-1:0]  hit_index_o,
  output logic [AMP_BITS-1:0]   ping_peak_o,
  output logic [CONF_W-1:0]     confidence_o
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned QW = CW + AMP_BITS;

  logic [PCT_W-1:0]    pct_q;
  logic [BLANK_W-1:0]  blank_q;
  logic                acc;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [AMP_BITS-1:0] wr_data;
  logic                push, pop, q_empty, active;
  logic [CW-1:0]       push_n;
  logic [AMP_BITS-1:0] push_peak;
  logic [QW-1:0]       pop_data;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                res_valid;
  result_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q   <= PCT_RESET;
      blank_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD_PERCENT: pct_q   <= cfg_data_i[PCT_W-1:0];
        REG_BLANKING_COUNT:    blank_q <= cfg_data_i[BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  assign acc  = start && !busy;
  assign busy = !q_empty || active;

  stbd_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk_i,
    .rst_ni,
    .acc_i       (acc),
    .amp_i       (sample_amplitude_i),
    .last_i      (ping_end_i),
    .blank_i     (blank_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_n_o    (push_n),
    .push_peak_o (push_peak)
  );

  stbd_queue #(.W(QW)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i ({push_n, push_peak}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  stbd_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  stbd_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i,
    .rst_ni,
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_valid_i (!q_empty),
    .job_n_i     (pop_data[QW-1:AMP_BITS]),
    .job_peak_i  (pop_data[AMP_BITS-1:0]),
    .job_pop_o   (pop),
    .pct_i       (pct_q),
    .blank_i     (blank_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .active_o    (active),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign done_o       = res_valid;
  assign found_o      = res.found;
  assign hit_index_o  = res.hit_index;
  assign ping_peak_o  = res.peak;
  assign confidence_o = res.conf;

endmodule

// ===== design/stbd_core_chk.sv =====
// Port-level checker for the bottom detector, bound to the top level.
// Depends on sonar_threshold_bottom_detect_core_macros.svh.
`include "sonar_threshold_bottom_detect_core_macros.svh"

module stbd_core_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        found_o,
  input logic [11:0] hit_index_o,
  input logic [15:0] ping_peak_o,
  input logic [15:0] confidence_o
);

  logic miss_is_clean, hit_has_peak;

  assign miss_is_clean = (hit_index_o == 12'd0) && (confidence_o == 16'd0);
  assign hit_has_peak  = ping_peak_o != 16'd0;

  `STBD_ASSERT_IMP(a_done_follows_busy, clk_i, rst_ni, done_o, $past(busy))
  `STBD_ASSERT_IMP(a_miss_zero_fields, clk_i, rst_ni, done_o && !found_o, miss_is_clean)
  `STBD_ASSERT_IMP(a_hit_nonzero_peak, clk_i, rst_ni, done_o && found_o, hit_has_peak)
  `STBD_ASSERT_NXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)

endmodule

bind sonar_threshold_bottom_detect_core stbd_core_chk u_stbd_core_chk (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the sonar bottom detector: sends pings, predicts each
// bottom report in step with the block, and compares every report as it appears.
// Depends on stbd_pkg and sonar_threshold_bottom_detect_core.
module tb_top import stbd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH  = MAX_SAMPLES_DEF;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned SETTLE_WAIT  = 4;
  localparam int unsigned TAIL_WAIT    = 80;
  localparam int unsigned PHASE_ITEMS  = 120;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [AMP_BITS-1:0]   sample_amplitude_i = '0;
  logic                  ping_end_i = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_THRESHOLD_PERCENT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  done_o;
  logic                  found_o;
  logic [IDX_OUT_W-1:0]  hit_index_o;
  logic [AMP_BITS-1:0]   ping_peak_o;
  logic [CONF_W-1:0]     confidence_o;

  logic [AMP_BITS-1:0] echo_mem [STORE_DEPTH];
  int unsigned         echo_count = 0;
  logic [AMP_BITS-1:0] echo_peak = '0;
  logic [PCT_W-1:0]    pct_reg = PCT_RESET;
  logic [BLANK_W-1:0]  blank_reg = '0;
  result_t             expected_bottoms [$];

  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  bit          gaps_on = 1'b1;

  sonar_threshold_bottom_detect_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .sample_amplitude_i (sample_amplitude_i),
    .ping_end_i         (ping_end_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .found_o            (found_o),
    .hit_index_o        (hit_index_o),
    .ping_peak_o        (ping_peak_o),
    .confidence_o       (confidence_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t bottom report mismatch, %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Store one sample and, on the last sample of a ping, queue the bottom report.
  task automatic track_sample(input logic [AMP_BITS-1:0] amp, input logic last);
    result_t             rpt;
    int unsigned         n;
    int unsigned         thr;
    int unsigned         half;
    int unsigned         i;
    logic [AMP_BITS-1:0] pk;
    if (echo_count < STORE_DEPTH) begin
      echo_mem[echo_count] = amp;
      if (echo_count >= blank_reg && amp > echo_peak) echo_peak = amp;
      echo_count++;
    end
    if (!last) return;
    n = echo_count;
    pk = echo_peak;
    echo_count = 0;
    echo_peak = '0;
    rpt = '0;
    rpt.peak = pk;
    if (pk != 0) begin
      thr = (int'(pk) * int'(pct_reg)) / 100;
      if (thr < 1) thr = 1;
      half = thr / 2;
      i = blank_reg;
      while (i < n && !rpt.found) begin
        if (echo_mem[i] >= thr && (i + 1 >= n || echo_mem[i + 1] >= half)) begin
          rpt.found = 1'b1;
          rpt.hit_index = i[IDX_OUT_W-1:0];
          rpt.conf = CONF_W'((longint'(echo_mem[i]) * 65535) / longint'(pk));
        end
        i++;
      end
    end
    expected_bottoms.push_back(rpt);
  endtask

  task automatic send_sample(input logic [AMP_BITS-1:0] amp, input logic last);
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    sample_amplitude_i <= amp;
    ping_end_i <= last;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    track_sample(amp, last);
    samples_sent++;
  endtask

  // Hold off until every report is in and the block has settled.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_bottoms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic set_detector(input logic [PCT_W-1:0] pct, input logic [BLANK_W-1:0] blank);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_THRESHOLD_PERCENT;
    cfg_data_i <= CFG_DATA_W'(pct);
    @(posedge clk_i);
    pct_reg = pct;
    cfg_idx_i <= REG_BLANKING_COUNT;
    cfg_data_i <= CFG_DATA_W'(blank);
    @(posedge clk_i);
    blank_reg = blank;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'd100, 1'b0);
    send_sample(16'd40, 1'b0);
    send_sample(16'd7, 1'b1);
  endtask

  task automatic test_zero_peak();
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b1);
  endtask

  task automatic test_unsustained_spike();
    set_detector(7'd60, 13'd0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd700, 1'b0);
    send_sample(16'd400, 1'b0);
    send_sample(16'd5, 1'b1);
  endtask

  task automatic test_last_sample_sustained();
    set_detector(7'd100, 13'd0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd30, 1'b1);
  endtask

  task automatic test_blanking();
    set_detector(7'd50, 13'd3);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd200, 1'b0);
    send_sample(16'd100, 1'b1);
    set_detector(7'd50, 13'h1FFF);
    send_sample(16'd500, 1'b0);
    send_sample(16'd600, 1'b0);
    send_sample(16'd700, 1'b1);
  endtask

  task automatic test_percent_extremes();
    set_detector(7'd0, 13'd0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd5, 1'b0);
    send_sample(16'd0, 1'b1);
    set_detector(7'd127, 13'd0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd1, 1'b1);
    set_detector(7'd100, 13'd0);
    send_sample(16'd1, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic send_random_ping();
    int unsigned         len;
    int unsigned         bottom;
    int unsigned         style;
    int unsigned         k;
    logic [AMP_BITS-1:0] amp;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    style = $urandom_range(0, 9);
    bottom = $urandom_range(0, len - 1);
    for (k = 0; k < len; k++) begin
      if (style < 2) amp = AMP_BITS'($urandom());
      else if (k < bottom) amp = AMP_BITS'($urandom_range(0, 3000));
      else if (k == bottom && style == 2) amp = AMP_BITS'($urandom_range(30000, 65535));
      else if (k == bottom + 1 && style == 2) amp = AMP_BITS'($urandom_range(0, 100));
      else amp = AMP_BITS'($urandom_range(5000, 65535));
      send_sample(amp, k == len - 1);
    end
  endtask

  task automatic test_random_pings();
    int unsigned        phase;
    int unsigned        phase_start;
    logic [PCT_W-1:0]   pct;
    logic [BLANK_W-1:0] blank;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          pct = 7'd50;
          blank = 13'd0;
        end
        1: begin
          pct = 7'd100;
          blank = 13'd0;
        end
        2: begin
          pct = 7'd0;
          blank = 13'd3;
        end
        3: begin
          pct = 7'd127;
          blank = 13'd1;
        end
        default: begin
          pct = PCT_W'($urandom_range(0, 127));
          blank = ($urandom_range(0, 3) == 0) ? 13'd50 : BLANK_W'($urandom_range(0, 12));
        end
      endcase
      set_detector(pct, blank);
      gaps_on = (phase != 4);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) send_random_ping();
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin : bottom_check
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_bottoms.size() == 0) begin
        report_mismatch("report with no ping pending", found_o, 0);
      end else begin
        want = expected_bottoms.pop_front();
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (hit_index_o !== want.hit_index)
          report_mismatch("hit_index", hit_index_o, want.hit_index);
        if (ping_peak_o !== want.peak) report_mismatch("ping_peak", ping_peak_o, want.peak);
        if (confidence_o !== want.conf)
          report_mismatch("confidence", confidence_o, want.conf);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && busy === 1'b0) || done_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_peak();
    test_unsustained_spike();
    test_last_sample_sustained();
    test_blanking();
    test_percent_extremes();
    test_random_pings();
    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
